### rtl/lcqt_pkg.sv
package lcqt_pkg;

    localparam int OUT_DATA_BITS = 56;
    localparam int NORM_BITS     = 18;

    // signals for one pipeline stage between two modules
    typedef struct packed {
        logic valid;
        logic advance;
    } stage_ctrl_t;

endpackage

### rtl/lattice_concyclic_quad_test_core.sv
// a transaction passes prep, cross, dot and result registers to reach the master side
// one quadruple per cycle unless stalled, stages advance separately so bubbles collapse
// a stalled master side holds the result; upstream stages keep filling empty slots
// reset: rst_n async active low clears all stage valid bits, payload is not reset
module lattice_concyclic_quad_test_core
    import lcqt_pkg::*;
#(
    parameter int COORD_BITS = 8
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // p0_x p0_y p0_z p1_x p1_y p1_z p2_x p2_y p2_z p3_x p3_y p3_z, zero pad
    input  logic [((12*COORD_BITS+7)/8)*8-1:0]     s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // is_concyclic normal_x normal_y normal_z is_symmetric
    output logic [OUT_DATA_BITS-1:0]               m_axis_tdata
);

    localparam int IN_BITS = ((12 * COORD_BITS + 7) / 8) * 8;
    localparam int XW      = 2 * COORD_BITS + 3;

    logic                           va, vb, vc, vd;
    logic                           adv_a, adv_b, adv_c, adv_d;
    stage_ctrl_t                    ctrl_b, ctrl_c, ctrl_d;

    logic signed [COORD_BITS:0]     d_a [3][3];
    logic signed [XW-1:0]           r_a [3];
    logic [2*COORD_BITS+1:0]        dist_a [6];

    logic signed [COORD_BITS:0]     d0_b [3];
    logic signed [XW-1:0]           r_b [3];
    logic signed [XW-1:0]           t_b [3];
    logic signed [XW-1:0]           cxy_b [3];
    logic signed [XW-1:0]           cxz_b [3];
    logic signed [XW-1:0]           cyz_b [3];
    logic signed [XW-1:0]           n01_b [3];
    logic signed [XW-1:0]           n02_b [3];
    logic                           sym_b;

    logic                           concyclic;
    logic                           symmetric;
    logic signed [NORM_BITS-1:0]    normal [3];

    // a stage moves when it is empty or the next one moves
    assign adv_d = !vd || m_axis_tready;
    assign adv_c = !vc || adv_d;
    assign adv_b = !vb || adv_c;
    assign adv_a = !va || adv_b;

    assign ctrl_b = '{valid: va, advance: adv_b};
    assign ctrl_c = '{valid: vb, advance: adv_c};
    assign ctrl_d = '{valid: vc, advance: adv_d};

    assign s_axis_tready = adv_a;
    assign m_axis_tvalid = vd;
    assign m_axis_tdata  = {symmetric, normal[2], normal[1], normal[0], concyclic};

    lcqt_prep #(
        .COORD_BITS (COORD_BITS),
        .IN_BITS    (IN_BITS)
    ) u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .advance   (adv_a),
        .tdata     (s_axis_tdata),
        .valid_reg (va),
        .d_reg     (d_a),
        .r_reg     (r_a),
        .dist_reg  (dist_a)
    );

    lcqt_cross #(
        .COORD_BITS (COORD_BITS)
    ) u_cross (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl_b),
        .d_in      (d_a),
        .r_in      (r_a),
        .dist_in   (dist_a),
        .valid_reg (vb),
        .d0_reg    (d0_b),
        .r_reg     (r_b),
        .t_reg     (t_b),
        .cxy_reg   (cxy_b),
        .cxz_reg   (cxz_b),
        .cyz_reg   (cyz_b),
        .n01_reg   (n01_b),
        .n02_reg   (n02_b),
        .sym_reg   (sym_b)
    );

    lcqt_dot #(
        .COORD_BITS (COORD_BITS)
    ) u_dot (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl_c        (ctrl_c),
        .ctrl_d        (ctrl_d),
        .d0_in         (d0_b),
        .r_in          (r_b),
        .t_in          (t_b),
        .cxy_in        (cxy_b),
        .cxz_in        (cxz_b),
        .cyz_in        (cyz_b),
        .n01_in        (n01_b),
        .n02_in        (n02_b),
        .sym_in        (sym_b),
        .valid_c_reg   (vc),
        .valid_d_reg   (vd),
        .concyclic_reg (concyclic),
        .normal_reg    (normal),
        .symmetric_reg (symmetric)
    );

    a_sym_needs_concyclic: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && symmetric |-> concyclic)
        else $error("symmetry flag set on a non-concyclic result");

    a_zero_normal: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !concyclic |-> (normal[0] == '0) && (normal[1] == '0)
            && (normal[2] == '0))
        else $error("normal not cleared for a non-concyclic result");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while the output stage is empty");

    a_output_fed: assert property (@(posedge clk) disable iff (!rst_n)
        vc && (!vd || m_axis_tready) |=> m_axis_tvalid)
        else $error("transaction lost between last two stages");

endmodule

### rtl/lcqt_prep.sv
module lcqt_prep
    import lcqt_pkg::*;
#(
    parameter int COORD_BITS = 8,
    parameter int IN_BITS    = 96
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           advance,
    input  logic [IN_BITS-1:0]             tdata,
    output logic                           valid_reg,
    output logic signed [COORD_BITS:0]     d_reg [3][3],
    output logic signed [2*COORD_BITS+2:0] r_reg [3],
    output logic [2*COORD_BITS+1:0]        dist_reg [6]
);

    localparam int C  = COORD_BITS;
    localparam int DW = C + 1;
    localparam int QW = 2 * C + 2;
    localparam int RW = 2 * C + 3;
    localparam int PA [6] = '{0, 0, 0, 1, 1, 2};
    localparam int PB [6] = '{1, 2, 3, 2, 3, 3};

    logic [C-1:0]            p [4][3];
    logic [QW-1:0]           q [4];
    logic signed [DW-1:0]    d_next [3][3];
    logic signed [RW-1:0]    r_next [3];
    logic signed [DW-1:0]    e [6][3];
    logic signed [QW-1:0]    sq [6][3];
    logic [QW-1:0]           dist_next [6];

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                p[i][j] = tdata[(3*i+j)*C +: C];
            end
            q[i] = QW'(p[i][0]) * QW'(p[i][0]) + QW'(p[i][1]) * QW'(p[i][1])
                 + QW'(p[i][2]) * QW'(p[i][2]);
        end
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                d_next[i][j] = $signed({1'b0, p[i+1][j]}) - $signed({1'b0, p[0][j]});
            end
            r_next[i] = $signed({1'b0, q[i+1]}) - $signed({1'b0, q[0]});
        end
        for (int k = 0; k < 6; k++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                e[k][j]  = $signed({1'b0, p[PA[k]][j]}) - $signed({1'b0, p[PB[k]][j]});
                sq[k][j] = QW'(e[k][j]) * QW'(e[k][j]);
            end
            dist_next[k] = $unsigned(sq[k][0] + sq[k][1] + sq[k][2]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            d_reg    <= d_next;
            r_reg    <= r_next;
            dist_reg <= dist_next;
        end
    end

endmodule

### rtl/lcqt_cross.sv
module lcqt_cross
    import lcqt_pkg::*;
#(
    parameter int COORD_BITS = 8
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  stage_ctrl_t                    ctrl,
    input  logic signed [COORD_BITS:0]     d_in [3][3],
    input  logic signed [2*COORD_BITS+2:0] r_in [3],
    input  logic [2*COORD_BITS+1:0]        dist_in [6],
    output logic                           valid_reg,
    output logic signed [COORD_BITS:0]     d0_reg [3],
    output logic signed [2*COORD_BITS+2:0] r_reg [3],
    output logic signed [2*COORD_BITS+2:0] t_reg [3],
    output logic signed [2*COORD_BITS+2:0] cxy_reg [3],
    output logic signed [2*COORD_BITS+2:0] cxz_reg [3],
    output logic signed [2*COORD_BITS+2:0] cyz_reg [3],
    output logic signed [2*COORD_BITS+2:0] n01_reg [3],
    output logic signed [2*COORD_BITS+2:0] n02_reg [3],
    output logic                           sym_reg
);

    localparam int DW = COORD_BITS + 1;
    localparam int XW = 2 * COORD_BITS + 3;

    typedef logic signed [DW-1:0] dv_t [3];
    typedef logic signed [XW-1:0] xv_t [3];

    function automatic xv_t cross3(input dv_t a, input dv_t b);
        xv_t o;
        o[0] = XW'(a[1]) * XW'(b[2]) - XW'(a[2]) * XW'(b[1]);
        o[1] = XW'(a[2]) * XW'(b[0]) - XW'(a[0]) * XW'(b[2]);
        o[2] = XW'(a[0]) * XW'(b[1]) - XW'(a[1]) * XW'(b[0]);
        return o;
    endfunction

    dv_t  row [3];
    dv_t  col [3];
    logic sym_next;
    // distances in order 01 02 03 12 13 23
    logic [2*COORD_BITS+1:0] d01, d02, d03, d12, d13, d23;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                row[i][j] = d_in[i][j];
                col[j][i] = d_in[i][j];
            end
        end
        d01 = dist_in[0];
        d02 = dist_in[1];
        d03 = dist_in[2];
        d12 = dist_in[3];
        d13 = dist_in[4];
        d23 = dist_in[5];
        sym_next = (d01 == d23) || ((d02 == d12) && (d03 == d13))
                || ((d02 == d03) && (d12 == d13))
                || (d02 == d13) || ((d01 == d12) && (d03 == d23))
                || ((d01 == d03) && (d12 == d23))
                || (d03 == d12) || ((d01 == d13) && (d02 == d23))
                || ((d01 == d02) && (d13 == d23));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctrl.advance)
        begin
            valid_reg <= ctrl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.advance)
        begin
            d0_reg  <= row[0];
            r_reg   <= r_in;
            t_reg   <= cross3(row[1], row[2]);
            cxy_reg <= cross3(col[0], col[1]);
            cxz_reg <= cross3(col[0], col[2]);
            cyz_reg <= cross3(col[1], col[2]);
            n01_reg <= cross3(row[0], row[1]);
            n02_reg <= cross3(row[0], row[2]);
            sym_reg <= sym_next;
        end
    end

endmodule

### rtl/lcqt_dot.sv
module lcqt_dot
    import lcqt_pkg::*;
#(
    parameter int COORD_BITS = 8
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  stage_ctrl_t                    ctrl_c,
    input  stage_ctrl_t                    ctrl_d,
    input  logic signed [COORD_BITS:0]     d0_in [3],
    input  logic signed [2*COORD_BITS+2:0] r_in [3],
    input  logic signed [2*COORD_BITS+2:0] t_in [3],
    input  logic signed [2*COORD_BITS+2:0] cxy_in [3],
    input  logic signed [2*COORD_BITS+2:0] cxz_in [3],
    input  logic signed [2*COORD_BITS+2:0] cyz_in [3],
    input  logic signed [2*COORD_BITS+2:0] n01_in [3],
    input  logic signed [2*COORD_BITS+2:0] n02_in [3],
    input  logic                           sym_in,
    output logic                           valid_c_reg,
    output logic                           valid_d_reg,
    output logic                           concyclic_reg,
    output logic signed [NORM_BITS-1:0]    normal_reg [3],
    output logic                           symmetric_reg
);

    localparam int C    = COORD_BITS;
    localparam int XW   = 2 * C + 3;
    localparam int PDW  = 3 * C + 4;
    localparam int DETW = 3 * C + 6;
    localparam int PRW  = 4 * C + 6;
    localparam int DOTW = 4 * C + 8;
    localparam int EXW  = XW + NORM_BITS;

    logic signed [XW-1:0]   cr [3];
    logic                   crnz_next;
    logic signed [PDW-1:0]  detp_next [3];
    logic signed [PRW-1:0]  dotp_next [3];
    logic signed [XW-1:0]   nrm_next [3];

    logic                   crnz_reg;
    logic                   sym_c_reg;
    logic signed [PDW-1:0]  detp_reg [3];
    logic signed [PRW-1:0]  dotp_reg [3];
    logic signed [XW-1:0]   nrm_reg [3];

    logic signed [DETW-1:0] det_sum;
    logic signed [DOTW-1:0] dot_sum;
    logic                   ok;
    logic signed [EXW-1:0]  ext [3];

    always_comb
    begin
        if ((cxy_in[0] != '0) || (cxy_in[1] != '0) || (cxy_in[2] != '0))
        begin
            cr = cxy_in;
        end
        else if ((cxz_in[0] != '0) || (cxz_in[1] != '0) || (cxz_in[2] != '0))
        begin
            cr = cxz_in;
        end
        else
        begin
            cr = cyz_in;
        end
        crnz_next = (cr[0] != '0) || (cr[1] != '0) || (cr[2] != '0);
        if ((n01_in[0] != '0) || (n01_in[1] != '0) || (n01_in[2] != '0))
        begin
            nrm_next = n01_in;
        end
        else
        begin
            nrm_next = n02_in;
        end
        for (int i = 0; i < 3; i++)
        begin
            detp_next[i] = PDW'(d0_in[i]) * PDW'(t_in[i]);
            dotp_next[i] = PRW'(cr[i]) * PRW'(r_in[i]);
        end
    end

    always_comb
    begin
        det_sum = DETW'(detp_reg[0]) + DETW'(detp_reg[1]) + DETW'(detp_reg[2]);
        dot_sum = DOTW'(dotp_reg[0]) + DOTW'(dotp_reg[1]) + DOTW'(dotp_reg[2]);
        ok = (det_sum == '0) && crnz_reg && (dot_sum == '0);
        for (int i = 0; i < 3; i++)
        begin
            ext[i] = EXW'(nrm_reg[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_c_reg <= 1'b0;
            valid_d_reg <= 1'b0;
        end
        else
        begin
            if (ctrl_c.advance)
            begin
                valid_c_reg <= ctrl_c.valid;
            end
            if (ctrl_d.advance)
            begin
                valid_d_reg <= ctrl_d.valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl_c.advance)
        begin
            crnz_reg  <= crnz_next;
            sym_c_reg <= sym_in;
            detp_reg  <= detp_next;
            dotp_reg  <= dotp_next;
            nrm_reg   <= nrm_next;
        end
        if (ctrl_d.advance)
        begin
            concyclic_reg <= ok;
            symmetric_reg <= ok && sym_c_reg;
            for (int i = 0; i < 3; i++)
            begin
                normal_reg[i] <= ok ? ext[i][NORM_BITS-1:0] : '0;
            end
        end
    end

endmodule
